// ===== rtl/core/rms_pkg.sv =====
// rms_pkg: word formats and command/status types for the record merge sorter
// no dependencies; imported by every module of the block
`default_nettype none

package rms_pkg;

    localparam int ID_W    = 31;
    localparam int DAY_W   = 5;
    localparam int MONTH_W = 4;
    localparam int YEAR_W  = 14;

    // one input word
    typedef struct packed {
        logic [ID_W-1:0]    rec_id;
        logic [DAY_W-1:0]   rec_day;
        logic [MONTH_W-1:0] rec_month;
        logic [YEAR_W-1:0]  rec_year;
        logic               rec_last;
    } rec_word_t;

    // one result word
    typedef struct packed {
        logic [ID_W-1:0]    out_id;
        logic [DAY_W-1:0]   out_day;
        logic [MONTH_W-1:0] out_month;
        logic [YEAR_W-1:0]  out_year;
        logic               out_final;
        logic               out_dropped;
    } res_word_t;

    // stored record, 54 bits
    typedef struct packed {
        logic [ID_W-1:0]    id;
        logic [DAY_W-1:0]   day;
        logic [MONTH_W-1:0] month;
        logic [YEAR_W-1:0]  year;
    } rec_t;

    // controller to datapath
    typedef struct packed {
        logic rd_en;      // capture both read ports of both buffers
        logic rd_sel;     // buffer that the selected read data comes from
        logic wr_en;
        logic wr_sel;     // buffer written
        logic wr_src_in;  // write the incoming record, else the merge winner
        logic take_a;     // merge winner is the left run head
    } rms_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic id_lt;      // left run head id strictly below right run head id
    } rms_stat_t;

endpackage

`default_nettype wire

// ===== rtl/core/rms_datapath.sv =====
// rms_datapath: two record buffers (ping-pong), read registers and key compare
// depends on rms_pkg
`default_nettype none

module rms_datapath
    import rms_pkg::*;
#(
    parameter int MAX_RECORDS = 64,
    localparam int ADDR_W = $clog2(MAX_RECORDS)
)(
    input  wire logic              clk,
    input  wire rms_cmd_t          cmd,
    output rms_stat_t              stat,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [ADDR_W-1:0] rd_addr_a,
    input  wire logic [ADDR_W-1:0] rd_addr_b,
    input  wire rec_t              in_rec,
    output rec_t                   rd_a
);

    rec_t mem0 [MAX_RECORDS];
    rec_t mem1 [MAX_RECORDS];

    rec_t m0_a_reg;
    rec_t m0_b_reg;
    rec_t m1_a_reg;
    rec_t m1_b_reg;
    logic rd_sel_reg;
    rec_t rd_b;
    rec_t wr_data;

    assign rd_a = rd_sel_reg ? m1_a_reg : m0_a_reg;
    assign rd_b = rd_sel_reg ? m1_b_reg : m0_b_reg;

    assign wr_data = cmd.wr_src_in ? in_rec : (cmd.take_a ? rd_a : rd_b);

    assign stat.id_lt = (rd_a.id < rd_b.id);

    always_ff @(posedge clk)
    begin
        if (cmd.wr_en && !cmd.wr_sel)
        begin
            mem0[wr_addr] <= wr_data;
        end
        if (cmd.rd_en)
        begin
            m0_a_reg <= mem0[rd_addr_a];
            m0_b_reg <= mem0[rd_addr_b];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.wr_en && cmd.wr_sel)
        begin
            mem1[wr_addr] <= wr_data;
        end
        if (cmd.rd_en)
        begin
            m1_a_reg <= mem1[rd_addr_a];
            m1_b_reg <= mem1[rd_addr_b];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.rd_en)
        begin
            rd_sel_reg <= cmd.rd_sel;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/rms_ctrl.sv =====
// rms_ctrl: load / merge-pass / emit sequencer with run pointers and counters
// depends on rms_pkg; drives rms_datapath by command and status structs
`default_nettype none

module rms_ctrl
    import rms_pkg::*;
#(
    parameter int MAX_RECORDS = 64,
    localparam int ADDR_W = $clog2(MAX_RECORDS),
    localparam int CNT_W  = $clog2(MAX_RECORDS + 1),
    localparam int SUM_W  = CNT_W + 2
)(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              rec_valid,
    output logic                   rec_ready,
    input  wire logic              rec_last,
    output logic                   res_valid,
    input  wire logic              res_ready,
    output logic                   res_final,
    output logic                   res_dropped,
    output rms_cmd_t               cmd,
    input  wire rms_stat_t         stat,
    output logic [ADDR_W-1:0]      wr_addr,
    output logic [ADDR_W-1:0]      rd_addr_a,
    output logic [ADDR_W-1:0]      rd_addr_b
);

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_PAIR,
        ST_RD,
        ST_WR,
        ST_OUT_RD,
        ST_OUT_WAIT
    } state_t;

    localparam logic [CNT_W-1:0] CAP = CNT_W'(MAX_RECORDS);

    state_t           state_reg,  state_next;
    logic [CNT_W-1:0] count_reg,  count_next;
    logic             ovf_reg,    ovf_next;
    logic [CNT_W-1:0] width_reg,  width_next;
    logic [CNT_W-1:0] lo_reg,     lo_next;
    logic [CNT_W-1:0] mid_reg,    mid_next;
    logic [CNT_W-1:0] hi_reg,     hi_next;
    logic [CNT_W-1:0] a_reg,      a_next;
    logic [CNT_W-1:0] b_reg,      b_next;
    logic [CNT_W-1:0] k_reg,      k_next;
    logic             src_reg,    src_next;
    logic             valid_reg,  valid_next;
    logic             final_reg,  final_next;

    logic             a_ok;
    logic             b_ok;
    logic             take_a;
    logic [SUM_W-1:0] lo_w;
    logic [SUM_W-1:0] lo_2w;
    logic [SUM_W-1:0] w_2;
    logic [SUM_W-1:0] n_ext;
    logic [CNT_W-1:0] k_inc;
    logic [CNT_W-1:0] count_inc;

    assign rec_ready   = (state_reg == ST_LOAD);
    assign res_valid   = valid_reg;
    assign res_final   = final_reg;
    assign res_dropped = ovf_reg;

    assign a_ok   = (a_reg < mid_reg);
    assign b_ok   = (b_reg < hi_reg);
    assign take_a = a_ok && (!b_ok || stat.id_lt);

    assign n_ext     = SUM_W'(count_reg);
    assign lo_w      = SUM_W'(lo_reg) + SUM_W'(width_reg);
    assign w_2       = SUM_W'(width_reg) << 1;
    assign lo_2w     = SUM_W'(lo_reg) + w_2;
    assign k_inc     = k_reg + CNT_W'(1);
    assign count_inc = count_reg + CNT_W'(1);

    assign wr_addr   = (state_reg == ST_LOAD) ? count_reg[ADDR_W-1:0] : k_reg[ADDR_W-1:0];
    assign rd_addr_a = (state_reg == ST_OUT_RD) ? k_reg[ADDR_W-1:0] : a_reg[ADDR_W-1:0];
    assign rd_addr_b = b_reg[ADDR_W-1:0];

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        ovf_next   = ovf_reg;
        width_next = width_reg;
        lo_next    = lo_reg;
        mid_next   = mid_reg;
        hi_next    = hi_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        k_next     = k_reg;
        src_next   = src_reg;
        valid_next = valid_reg;
        final_next = final_reg;

        cmd           = '0;
        cmd.rd_sel    = src_reg;
        cmd.wr_sel    = ~src_reg;
        cmd.take_a    = take_a;

        case (state_reg)
            ST_LOAD:
            begin
                if (rec_valid)
                begin
                    if (count_reg < CAP)
                    begin
                        cmd.wr_en     = 1'b1;
                        cmd.wr_sel    = 1'b0;
                        cmd.wr_src_in = 1'b1;
                        count_next    = count_inc;
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                    if (rec_last)
                    begin
                        src_next   = 1'b0;
                        width_next = CNT_W'(1);
                        lo_next    = '0;
                        k_next     = '0;
                        if (count_next > CNT_W'(1))
                        begin
                            state_next = ST_PAIR;
                        end
                        else
                        begin
                            state_next = ST_OUT_RD;
                        end
                    end
                end
            end

            ST_PAIR:
            begin
                // left run [lo, mid), right run [mid, hi), both clipped at n
                mid_next   = (lo_w < n_ext) ? lo_w[CNT_W-1:0] : count_reg;
                hi_next    = (lo_2w < n_ext) ? lo_2w[CNT_W-1:0] : count_reg;
                a_next     = lo_reg;
                b_next     = (lo_w < n_ext) ? lo_w[CNT_W-1:0] : count_reg;
                k_next     = lo_reg;
                state_next = ST_RD;
            end

            ST_RD:
            begin
                cmd.rd_en  = 1'b1;
                state_next = ST_WR;
            end

            ST_WR:
            begin
                cmd.wr_en = 1'b1;
                a_next    = take_a ? a_reg + CNT_W'(1) : a_reg;
                b_next    = take_a ? b_reg : b_reg + CNT_W'(1);
                k_next    = k_inc;
                if (k_inc == hi_reg)
                begin
                    if (lo_2w >= n_ext)
                    begin
                        // pass done, sorted data now sits in the other buffer
                        src_next = ~src_reg;
                        if (w_2 >= n_ext)
                        begin
                            k_next     = '0;
                            state_next = ST_OUT_RD;
                        end
                        else
                        begin
                            width_next = w_2[CNT_W-1:0];
                            lo_next    = '0;
                            state_next = ST_PAIR;
                        end
                    end
                    else
                    begin
                        lo_next    = lo_2w[CNT_W-1:0];
                        state_next = ST_PAIR;
                    end
                end
                else
                begin
                    state_next = ST_RD;
                end
            end

            ST_OUT_RD:
            begin
                cmd.rd_en  = 1'b1;
                valid_next = 1'b1;
                final_next = (k_inc == count_reg);
                state_next = ST_OUT_WAIT;
            end

            ST_OUT_WAIT:
            begin
                if (res_ready)
                begin
                    valid_next = 1'b0;
                    if (final_reg)
                    begin
                        count_next = '0;
                        ovf_next   = 1'b0;
                        final_next = 1'b0;
                        state_next = ST_LOAD;
                    end
                    else
                    begin
                        k_next     = k_inc;
                        state_next = ST_OUT_RD;
                    end
                end
            end

            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
            count_reg <= '0;
            ovf_reg   <= 1'b0;
            width_reg <= '0;
            lo_reg    <= '0;
            mid_reg   <= '0;
            hi_reg    <= '0;
            a_reg     <= '0;
            b_reg     <= '0;
            k_reg     <= '0;
            src_reg   <= 1'b0;
            valid_reg <= 1'b0;
            final_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
            width_reg <= width_next;
            lo_reg    <= lo_next;
            mid_reg   <= mid_next;
            hi_reg    <= hi_next;
            a_reg     <= a_next;
            b_reg     <= b_next;
            k_reg     <= k_next;
            src_reg   <= src_next;
            valid_reg <= valid_next;
            final_reg <= final_next;
        end
    end

    // a last word always leaves at least one record to emit
    a_last_starts_sort: assert property (@(posedge clk) disable iff (!rst_n)
        (rec_valid && rec_ready && rec_last) |=> (state_reg != ST_LOAD))
        else $error("last word did not start the sort");

    // a merge write always has a run head to take
    a_merge_has_head: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WR) |-> (a_reg < mid_reg || b_reg < hi_reg))
        else $error("merge write with both runs exhausted");

    // pair setup only for runs inside the stored set
    a_pair_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_PAIR) |-> (width_reg < count_reg && lo_reg < count_reg))
        else $error("merge pair outside the stored set");

    // a held result keeps its place in the sorted run
    a_hold_index: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !res_ready) |=> (res_valid && $stable(k_reg)))
        else $error("output index moved while stalled");

    // taking the final word empties the set
    a_final_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res_ready && res_final) |=> (state_reg == ST_LOAD && count_reg == '0
            && !ovf_reg))
        else $error("set not cleared after final word");

endmodule

`default_nettype wire

// ===== rtl/core/record_merge_sort_by_id.sv =====
// record_merge_sort_by_id: top level, collects records and emits them sorted by id
// depends on rms_pkg, rms_ctrl, rms_datapath
//
//   channel  signals                          word type   direction
//   rec      rec_valid rec_ready rec_word     rec_word_t  into block
//   res      res_valid res_ready res_word     res_word_t  out of block
//
// loading takes one word per cycle; a word marked last closes the set
// sorting runs ceil(log2 n) merge passes; each pair of runs starts with a setup state (ST_PAIR),
//   then every merged record takes a buffer read (ST_RD) and a buffer write (ST_WR)
// emitting reads each word from the buffer (ST_OUT_RD), then holds it until taken (ST_OUT_WAIT)
// reset (rst_n low, async) empties the set; buffer contents are not cleared
// rec_ready is high only while loading; a stall on res holds the current word
`default_nettype none

module record_merge_sort_by_id
    import rms_pkg::*;
#(
    parameter int MAX_RECORDS = 64
)(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      rec_valid,
    output logic           rec_ready,
    input  wire rec_word_t rec_word,
    output logic           res_valid,
    input  wire logic      res_ready,
    output res_word_t      res_word
);

    localparam int ADDR_W = $clog2(MAX_RECORDS);

    rms_cmd_t          cmd;
    rms_stat_t         stat;
    logic [ADDR_W-1:0] wr_addr;
    logic [ADDR_W-1:0] rd_addr_a;
    logic [ADDR_W-1:0] rd_addr_b;
    rec_t              in_rec;
    rec_t              rd_a;
    logic              res_final;
    logic              res_dropped;

    // incoming record without the last mark
    assign in_rec.id    = rec_word.rec_id;
    assign in_rec.day   = rec_word.rec_day;
    assign in_rec.month = rec_word.rec_month;
    assign in_rec.year  = rec_word.rec_year;

    // sequencer: load count, overflow flag, merge pass pointers, emit index
    rms_ctrl #(
        .MAX_RECORDS (MAX_RECORDS)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .rec_valid   (rec_valid),
        .rec_ready   (rec_ready),
        .rec_last    (rec_word.rec_last),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res_final   (res_final),
        .res_dropped (res_dropped),
        .cmd         (cmd),
        .stat        (stat),
        .wr_addr     (wr_addr),
        .rd_addr_a   (rd_addr_a),
        .rd_addr_b   (rd_addr_b)
    );

    // ping-pong buffers; merge passes alternate source and destination
    // ties go to the right run, so equal ids leave in reverse arrival order
    rms_datapath #(
        .MAX_RECORDS (MAX_RECORDS)
    ) u_datapath (
        .clk       (clk),
        .cmd       (cmd),
        .stat      (stat),
        .wr_addr   (wr_addr),
        .rd_addr_a (rd_addr_a),
        .rd_addr_b (rd_addr_b),
        .in_rec    (in_rec),
        .rd_a      (rd_a)
    );

    // result word: read register of the sorted buffer plus run flags
    assign res_word.out_id      = rd_a.id;
    assign res_word.out_day     = rd_a.day;
    assign res_word.out_month   = rd_a.month;
    assign res_word.out_year    = rd_a.year;
    assign res_word.out_final   = res_final;
    assign res_word.out_dropped = res_dropped;

endmodule

`default_nettype wire

// ===== test/record_merge_sort_by_id_tb.sv =====
// record_merge_sort_by_id_tb: self-checking testbench for the record merge sorter
// depends on rms_pkg (word types) and record_merge_sort_by_id (the block under test)
// sends record sets over rec, predicts each sorted run, checks every word on res

module record_merge_sort_by_id_tb;

    import rms_pkg::*;

    localparam int CAPACITY       = 64;     // MAX_RECORDS of the instance
    localparam int SINK_HOLD      = 300;    // long receiver hold-off, in cycles
    localparam int WATCHDOG_LIMIT = 5000;   // cycles with no word moving on either side
    localparam int TAIL_CYCLES    = 60;     // quiet time after the last expected word
    localparam int RANDOM_WORDS   = 70;
    localparam int MAX_SHOWN      = 40;     // mismatch reports printed

    // how the id of a random record is drawn
    localparam int ID_ANY    = 0;   // full 31-bit range
    localparam int ID_NARROW = 1;   // 0..15, lots of equal keys
    localparam int ID_CORNER = 2;   // extremes and mid-range boundaries

    // one row of the directed table; exp is used only where has_exp is set
    typedef struct packed {
        rec_word_t w;
        logic      has_exp;
        res_word_t exp;
    } stim_row_t;

    logic      clk = 1'b0;
    logic      rst_n;
    logic      rec_valid;
    logic      rec_ready;
    rec_word_t rec_word;
    logic      res_valid;
    logic      res_ready;
    res_word_t res_word;

    // sorter model state
    rec_t held_recs [CAPACITY];
    rec_t merge_tmp [CAPACITY];
    int   held_count = 0;
    bit   lost_flag  = 1'b0;

    res_word_t pending_results [$];   // sorted words still owed by the block
    stim_row_t dir_rows [$];

    int  err_count     = 0;
    int  shown_errors  = 0;
    int  idle_cycles   = 0;
    int  sets_sent     = 0;
    int  records_sent  = 0;
    int  results_seen  = 0;
    int  dropped_runs  = 0;
    int  longest_run   = 0;
    bit  sink_park     = 1'b0;        // asks the receiver for one long hold-off

    always #5 clk = ~clk;

    record_merge_sort_by_id #(
        .MAX_RECORDS (CAPACITY)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .rec_valid (rec_valid),
        .rec_ready (rec_ready),
        .rec_word  (rec_word),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_word  (res_word)
    );

    // ------------------------------------------------------------------
    // sorter model
    // ------------------------------------------------------------------

    // merge held_recs[lo..mid] with held_recs[mid+1..hi]; the left head wins
    // only on a strictly smaller id, so equal keys come out right half first
    function automatic void merge_runs(input int lo, input int mid, input int hi);
        int a;
        int b;
        int k;
        a = lo;
        b = mid + 1;
        for (k = lo; k <= hi; k++)
        begin
            if (a <= mid && (b > hi || held_recs[a].id < held_recs[b].id))
            begin
                merge_tmp[k] = held_recs[a];
                a++;
            end
            else
            begin
                merge_tmp[k] = held_recs[b];
                b++;
            end
        end
        for (k = lo; k <= hi; k++)
            held_recs[k] = merge_tmp[k];
    endfunction

    // top-down merge sort of the held set, split at (lo+hi)/2, walked with an
    // explicit stack: step 0 sorts the left half, 1 the right half, 2 merges
    function automatic void sort_held();
        int lo_stk   [16];
        int hi_stk   [16];
        int step_stk [16];
        int sp;
        int lo;
        int hi;
        int mid;
        if (held_count < 2)
            return;
        sp = 0;
        lo_stk[0]   = 0;
        hi_stk[0]   = held_count - 1;
        step_stk[0] = 0;
        while (sp >= 0)
        begin
            lo  = lo_stk[sp];
            hi  = hi_stk[sp];
            mid = (lo + hi) / 2;
            if (lo >= hi)
                sp--;
            else if (step_stk[sp] == 0)
            begin
                step_stk[sp] = 1;
                sp++;
                lo_stk[sp] = lo;  hi_stk[sp] = mid;  step_stk[sp] = 0;
            end
            else if (step_stk[sp] == 1)
            begin
                step_stk[sp] = 2;
                sp++;
                lo_stk[sp] = mid + 1;  hi_stk[sp] = hi;  step_stk[sp] = 0;
            end
            else
            begin
                merge_runs(lo, mid, hi);
                sp--;
            end
        end
    endfunction

    // account for one accepted record word; a word marked last closes the set
    // and queues the whole sorted run
    function automatic void absorb_word(input rec_word_t w, input logic typed_ok,
                                        input res_word_t typed);
        res_word_t e;
        int        k;
        if (held_count < CAPACITY)
        begin
            held_recs[held_count] = '{id: w.rec_id, day: w.rec_day,
                                      month: w.rec_month, year: w.rec_year};
            held_count++;
        end
        else
            lost_flag = 1'b1;   // store full: the record is discarded
        if (!w.rec_last)
            return;
        sort_held();
        for (k = 0; k < held_count; k++)
        begin
            e.out_id      = held_recs[k].id;
            e.out_day     = held_recs[k].day;
            e.out_month   = held_recs[k].month;
            e.out_year    = held_recs[k].year;
            e.out_final   = (k == held_count - 1);
            e.out_dropped = lost_flag;
            pending_results.push_back(typed_ok ? typed : e);
        end
        sets_sent++;
        if (lost_flag)
            dropped_runs++;
        if (held_count > longest_run)
            longest_run = held_count;
        held_count = 0;
        lost_flag  = 1'b0;
    endfunction

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------

    function automatic void add_row(input rec_word_t w, input logic has_exp,
                                    input res_word_t exp);
        dir_rows.push_back({w, has_exp, exp});
    endfunction

    // mostly back to back, some short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(5, 40);
    endfunction

    function automatic rec_word_t rand_word(input int id_mode, input logic last);
        rec_word_t w;
        case (id_mode)
            ID_NARROW: w.rec_id = 31'($urandom_range(0, 15));
            ID_CORNER:
                case ($urandom_range(0, 3))
                    0:       w.rec_id = '0;
                    1:       w.rec_id = '1;
                    2:       w.rec_id = 31'h4000_0000;
                    default: w.rec_id = 31'h3FFF_FFFF;
                endcase
            default:   w.rec_id = 31'($urandom);
        endcase
        // payload fields span their whole width, out-of-range values included
        w.rec_day   = 5'($urandom);
        w.rec_month = 4'($urandom);
        w.rec_year  = 14'($urandom);
        w.rec_last  = last;
        return w;
    endfunction

    // present one word at the falling edge and hold it until taken
    task automatic offer_word(input rec_word_t w, input int gap);
        repeat (gap)
        begin
            @(negedge clk);
            rec_valid <= 1'b0;
        end
        @(negedge clk);
        rec_valid <= 1'b1;
        rec_word  <= w;
        do
            @(posedge clk);
        while (!rec_ready);
        records_sent++;
    endtask

    // one random set; tight sets go without any sender gap
    task automatic send_set(input int size, input int id_mode, input bit tight);
        rec_word_t w;
        int        i;
        for (i = 0; i < size; i++)
        begin
            w = rand_word(id_mode, i == size - 1);
            offer_word(w, tight ? 0 : pick_gap());
            absorb_word(w, 1'b0, '0);
        end
    endtask

    // the word just taken must not stay offered while the sender waits
    task automatic wait_drained();
        @(negedge clk);
        rec_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // result checking
    // ------------------------------------------------------------------

    function automatic bit field_differs(input string name, input logic [31:0] want,
                                         input logic [31:0] got);
        if (want === got)
            return 1'b0;
        if (shown_errors < MAX_SHOWN)
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
        shown_errors++;
        return 1'b1;
    endfunction

    // compare every accepted result word against the oldest prediction
    always @(posedge clk)
    begin
        res_word_t want;
        bit        bad;
        if (rst_n === 1'b1 && res_valid === 1'b1 && res_ready === 1'b1)
        begin
            results_seen++;
            if (pending_results.size() == 0)
            begin
                err_count++;
                if (shown_errors < MAX_SHOWN)
                    $display("%0t: unexpected result word, expected none, got %h",
                             $time, res_word);
                shown_errors++;
            end
            else
            begin
                want = pending_results.pop_front();
                bad  = 1'b0;
                bad |= field_differs("out_id",      want.out_id,      res_word.out_id);
                bad |= field_differs("out_day",     want.out_day,     res_word.out_day);
                bad |= field_differs("out_month",   want.out_month,   res_word.out_month);
                bad |= field_differs("out_year",    want.out_year,    res_word.out_year);
                bad |= field_differs("out_final",   want.out_final,   res_word.out_final);
                bad |= field_differs("out_dropped", want.out_dropped, res_word.out_dropped);
                if (bad)
                    err_count++;
            end
        end
    end

    // watchdog: too long without a word moving on either channel
    always @(posedge clk)
    begin
        if ((rec_valid === 1'b1 && rec_ready === 1'b1) ||
            (res_valid === 1'b1 && res_ready === 1'b1))
            idle_cycles = 0;
        else
        begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t: no word moved for %0d cycles", $time, WATCHDOG_LIMIT);
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // receiver: ready pattern changes at the falling edge
    // ------------------------------------------------------------------

    initial
    begin
        int r;
        int len;
        bit lvl;
        res_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            r = $urandom_range(0, 99);
            if (sink_park)
            begin
                // long stall so the block fills and backs up its input
                sink_park = 1'b0;
                lvl = 1'b0;
                len = SINK_HOLD;
            end
            else if (r < 50)
            begin
                lvl = 1'b1;
                len = $urandom_range(1, 30);
            end
            else if (r < 85)
            begin
                lvl = 1'b0;
                len = $urandom_range(1, 3);
            end
            else if (r < 95)
            begin
                lvl = 1'b1;
                len = $urandom_range(1, 4);
            end
            else
            begin
                lvl = 1'b0;
                len = $urandom_range(10, 60);
            end
            repeat (len)
            begin
                @(negedge clk);
                res_ready <= lvl;
            end
        end
    end

    // ------------------------------------------------------------------
    // sender and run control
    // ------------------------------------------------------------------

    initial
    begin
        int r;
        int size;
        int random_sent;
        int set_no;

        rst_n     = 1'b0;
        rec_valid = 1'b0;
        rec_word  = '0;

        // single-record sets: the run is the record itself, final set, none dropped
        add_row({31'h7FFF_FFFF, 5'd31, 4'd15, 14'h3FFF, 1'b1}, 1'b1,
                {31'h7FFF_FFFF, 5'd31, 4'd15, 14'h3FFF, 1'b1, 1'b0});
        add_row({31'h0, 5'd0, 4'd0, 14'd0, 1'b1}, 1'b1,
                {31'h0, 5'd0, 4'd0, 14'd0, 1'b1, 1'b0});
        add_row({31'h0001_2345, 5'd12, 4'd12, 14'd9999, 1'b1}, 1'b1,
                {31'h0001_2345, 5'd12, 4'd12, 14'd9999, 1'b1, 1'b0});
        // equal ids split across halves: right half wins the tie
        add_row({31'd9, 5'd1, 4'd1, 14'd2001, 1'b0}, 1'b0, '0);
        add_row({31'd9, 5'd2, 4'd2, 14'd2002, 1'b0}, 1'b0, '0);
        add_row({31'd3, 5'd3, 4'd3, 14'd2003, 1'b0}, 1'b0, '0);
        add_row({31'd9, 5'd4, 4'd4, 14'd2004, 1'b1}, 1'b0, '0);
        // strictly descending ids
        add_row({31'd60, 5'd6, 4'd6, 14'd60, 1'b0}, 1'b0, '0);
        add_row({31'd50, 5'd5, 4'd5, 14'd50, 1'b0}, 1'b0, '0);
        add_row({31'd40, 5'd4, 4'd4, 14'd40, 1'b0}, 1'b0, '0);
        add_row({31'd30, 5'd3, 4'd3, 14'd30, 1'b0}, 1'b0, '0);
        add_row({31'd20, 5'd2, 4'd2, 14'd20, 1'b0}, 1'b0, '0);
        add_row({31'd10, 5'd1, 4'd1, 14'd10, 1'b1}, 1'b0, '0);
        // already sorted
        add_row({31'd1, 5'd31, 4'd0, 14'd1, 1'b0}, 1'b0, '0);
        add_row({31'd2, 5'd30, 4'd1, 14'd2, 1'b0}, 1'b0, '0);
        add_row({31'd3, 5'd29, 4'd2, 14'd3, 1'b0}, 1'b0, '0);
        add_row({31'd4, 5'd28, 4'd3, 14'd4, 1'b1}, 1'b0, '0);
        // all keys equal
        add_row({31'h55, 5'd7, 4'd8, 14'd1111, 1'b0}, 1'b0, '0);
        add_row({31'h55, 5'd8, 4'd9, 14'd2222, 1'b0}, 1'b0, '0);
        add_row({31'h55, 5'd9, 4'd10, 14'd3333, 1'b1}, 1'b0, '0);
        // extreme and boundary ids
        add_row({31'h7FFF_FFFF, 5'd0, 4'd15, 14'h0, 1'b0}, 1'b0, '0);
        add_row({31'h0, 5'd31, 4'd0, 14'h3FFF, 1'b0}, 1'b0, '0);
        add_row({31'h4000_0000, 5'd16, 4'd8, 14'h2000, 1'b0}, 1'b0, '0);
        add_row({31'h3FFF_FFFF, 5'd15, 4'd7, 14'h1FFF, 1'b0}, 1'b0, '0);
        add_row({31'h1, 5'd1, 4'd1, 14'h1, 1'b1}, 1'b0, '0);

        // reset once, released at a falling edge
        repeat (3)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (dir_rows[i])
        begin
            offer_word(dir_rows[i].w, pick_gap());
            absorb_word(dir_rows[i].w, dir_rows[i].has_exp, dir_rows[i].exp);
        end

        // sender pause: nothing offered until every owed word is back
        wait_drained();

        // capacity: a set that fills the store and overruns it (the last two words,
        // the one marked last included, are discarded; the stored records still sort)
        send_set(CAPACITY + 2, ID_NARROW, 1'b1);

        // random sets, mostly small
        random_sent = 0;
        set_no      = 0;
        while (random_sent < RANDOM_WORDS)
        begin
            r = $urandom_range(0, 99);
            if (r < 70)
                size = $urandom_range(1, 6);
            else if (r < 90)
                size = $urandom_range(7, 20);
            else
                size = $urandom_range(21, 40);
            if (set_no == 1)
            begin
                // receiver parks while this set and the next one are offered
                sink_park = 1'b1;
                size = 12;
            end
            send_set(size, $urandom_range(ID_ANY, ID_CORNER), $urandom_range(0, 3) == 0);
            random_sent += size;
            set_no++;
            if ($urandom_range(0, 9) == 0)
                wait_drained();
        end

        @(negedge clk);
        rec_valid <= 1'b0;

        wait_drained();
        repeat (TAIL_CYCLES)
            @(posedge clk);

        $display("sent %0d records in %0d sets, %0d sorted words checked",
                 records_sent, sets_sent, results_seen);
        $display("sets with discarded records: %0d, longest sorted run: %0d",
                 dropped_runs, longest_run);
        if (err_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
